// ----- hdl/lifo_stack_with_search_unit_assert.svh -----
// Assertion macros for the stack RTL, included by the stack sequencer.
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LSS_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("lss assertion failed");
`define LSS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("lss assertion failed");
`else
`define LSS_ASSERT_NOW(lbl, clk, rstn, pre, post)
`define LSS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ----- hdl/lss_pkg.sv -----
// Types and constants shared by the LIFO stack with search.
package lss_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 7;
    localparam int ACTION_W      = 3;
    localparam int STATUS_W      = 2;
    localparam int OUT_W         = 48;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_COUNT  = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_status                    status;
        logic [COUNT_W-1:0]         count;
        logic                       found;
        logic signed [VALUE_W-1:0]  value;
    } t_result;

endpackage

// ----- hdl/lifo_stack_with_search_unit.sv -----
// Top level of the LIFO stack with search: stream ports and output register.
// Push, count, clear, spare codes, every error case: result registered, then output register.
// Pop and peek: a read state waits on the registered read of the entry memory.
// Search: one stored entry compared per cycle from the top down, to a hit or the bottom.
// One item at a time; the next transfer is taken no earlier than the edge at which the
// previous result leaves. Synchronous active-low reset empties the stack and drops results.
module lifo_stack_with_search_unit #(
    parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [31:0] operand_value
    input  logic [lss_pkg::VALUE_W-1:0] s_axis_tdata,
    // [2:0] action
    input  logic [lss_pkg::ACTION_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [31:0] result_value, [32] found, [39:33] entry_count, [41:40] status, [47:42] zero
    output logic [lss_pkg::OUT_W-1:0] m_axis_tdata
);

    logic                        start;
    logic                        busy;
    logic                        done;
    lss_pkg::t_result            result;
    logic                        r_oval;
    logic [lss_pkg::OUT_W-1:0]   r_odata;

    // Take an item only when the sequencer is idle and the output slot frees up.
    assign s_axis_tready = !busy && (!r_oval || m_axis_tready);
    assign start         = s_axis_tvalid && s_axis_tready;

    lss_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_action  (lss_pkg::t_action'(s_axis_tuser)),
        .i_operand (s_axis_tdata),
        .o_busy    (busy),
        .o_done    (done),
        .o_result  (result)
    );

    // Output register holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (done) begin
            r_oval <= 1'b1;
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
        if (done) begin
            r_odata <= lss_pkg::OUT_W'(result);
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

endmodule

// ----- hdl/lss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lss_seq.sv -----
// Stack sequencer: pointer, entry memory and the shared compare unit for search.
`include "lifo_stack_with_search_unit_assert.svh"
module lss_seq #(
    parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  lss_pkg::t_action                    i_action,
    input  logic signed [lss_pkg::VALUE_W-1:0]  i_operand,
    output logic                                o_busy,
    output logic                                o_done,
    output lss_pkg::t_result                    o_result
);

    localparam int PTRW = $clog2(DEPTH + 1);
    localparam int IDXW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    t_state                              r_state, n_state;
    logic [PTRW-1:0]                     r_ptr, n_ptr;
    logic                                r_done, n_done;
    lss_pkg::t_result                    r_res, n_res;
    logic [IDXW-1:0]                     r_idx, n_idx;
    logic signed [lss_pkg::VALUE_W-1:0]  r_key, n_key;
    logic                                r_pop, n_pop;

    logic [PTRW-1:0]                     ptr_m1;
    logic [PTRW-1:0]                     ptr_p1;
    logic                                ram_we;
    logic [IDXW-1:0]                     ram_raddr;
    logic signed [lss_pkg::VALUE_W-1:0]  ram_rdata;
    logic                                hit;

    assign ptr_m1 = r_ptr - PTRW'(1);
    assign ptr_p1 = r_ptr + PTRW'(1);

    // The scan reads one entry below the one whose data is arriving.
    assign ram_raddr = (r_state == S_SCAN) ? (r_idx - IDXW'(1)) : ptr_m1[IDXW-1:0];
    assign ram_we    = i_start && (i_action == lss_pkg::ACT_PUSH) &&
                       (r_ptr != PTRW'(DEPTH));

    // Shared compare unit, one stored entry per cycle.
    assign hit = (ram_rdata == r_key);

    lss_ram #(
        .WIDTH (lss_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr[IDXW-1:0]),
        .i_wdata (i_operand),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next-state and result logic.
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_done  = 1'b0;
        n_res   = r_res;
        n_idx   = r_idx;
        n_key   = r_key;
        n_pop   = r_pop;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res.value  = '0;
                    n_res.found  = 1'b0;
                    n_res.status = lss_pkg::ST_OK;
                    n_done       = 1'b1;
                    unique case (i_action) inside
                        lss_pkg::ACT_PUSH: begin
                            if (r_ptr == PTRW'(DEPTH)) begin
                                n_res.status = lss_pkg::ST_FULL;
                            end else begin
                                n_ptr = ptr_p1;
                            end
                        end
                        lss_pkg::ACT_POP, lss_pkg::ACT_PEEK: begin
                            if (r_ptr == '0) begin
                                n_res.status = lss_pkg::ST_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_pop   = (i_action == lss_pkg::ACT_POP);
                                n_state = S_READ;
                            end
                        end
                        lss_pkg::ACT_SEARCH: begin
                            if (r_ptr == '0) begin
                                n_res.status = lss_pkg::ST_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_key   = i_operand;
                                n_idx   = ptr_m1[IDXW-1:0];
                                n_state = S_SCAN;
                            end
                        end
                        lss_pkg::ACT_CLEAR: begin
                            n_ptr = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_res.count = lss_pkg::COUNT_W'(n_ptr);
                end
            end
            S_READ: begin
                n_res.value = ram_rdata;
                if (r_pop) begin
                    n_ptr = ptr_m1;
                end
                n_res.count = lss_pkg::COUNT_W'(n_ptr);
                n_done      = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                if (hit || (r_idx == '0)) begin
                    n_res.found = hit;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx - IDXW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, pointer and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_done  <= n_done;
        end
        r_res <= n_res;
        r_idx <= n_idx;
        r_key <= n_key;
        r_pop <= n_pop;
    end

    assign o_busy   = (r_state != S_IDLE) || r_done;
    assign o_done   = r_done;
    assign o_result = r_res;

    `LSS_ASSERT_NOW(a_ptr_bound, i_clk, i_rst_n, 1'b1, r_ptr <= PTRW'(DEPTH))
    `LSS_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `LSS_ASSERT_NOW(a_scan_nonempty, i_clk, i_rst_n, r_state == S_SCAN, r_ptr != '0)
    `LSS_ASSERT_NOW(a_full_status, i_clk, i_rst_n,
        r_done && (r_res.status == lss_pkg::ST_FULL), r_ptr == PTRW'(DEPTH))

endmodule

// ----- sim/lifo_stack_with_search_unit_tb.sv -----
// Self-checking testbench for the LIFO stack with search: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module lifo_stack_with_search_unit_tb;

    localparam int DEPTH        = lss_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 40;
    localparam int AW           = lss_pkg::ACTION_W;
    localparam int VW           = lss_pkg::VALUE_W;

    // Action codes that the block treats as no operation.
    localparam logic [AW-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [AW-1:0] ACT_SPARE_7 = 3'd7;

    // One stack command as it travels on the slave side.
    typedef struct packed {
        logic [AW-1:0] action;
        logic [VW-1:0] operand;
    } t_stack_cmd;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [VW-1:0]               s_axis_tdata = '0;
    logic [AW-1:0]               s_axis_tuser = lss_pkg::ACT_COUNT;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [lss_pkg::OUT_W-1:0]   m_axis_tdata;

    // Commands waiting to be driven, and results the stack should return.
    t_stack_cmd                  pending_cmds[$];
    lss_pkg::t_result            expected_results[$];

    // Predicted stack contents.
    logic [VW-1:0]               stack_mem[DEPTH];
    int                          stack_top = 0;

    // Stack contents as the command generator sees them, to aim searches at held values.
    logic [VW-1:0]               gen_stack[$];

    int                          total_cmds = 1;
    int                          sent_count = 0;
    int                          result_count = 0;
    int                          err_count = 0;
    int                          cycle_count = 0;

    lifo_stack_with_search_unit #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reset release from the cycle counter, plus the run-away guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_rst_n <= (cycle_count >= 8);
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lifo_stack_with_search_unit regression: fail");
            $finish;
        end
    end

    // Computes the result of one command and updates the predicted stack.
    function automatic lss_pkg::t_result stack_predict(input logic [AW-1:0] act,
                                                       input logic [VW-1:0] operand);
        lss_pkg::t_result r;
        int               i;
        r = '0;
        r.status = lss_pkg::ST_OK;
        case (act)
            lss_pkg::ACT_PUSH: begin
                if (stack_top >= DEPTH) begin
                    r.status = lss_pkg::ST_FULL;
                end else begin
                    stack_mem[stack_top] = operand;
                    stack_top++;
                end
            end
            lss_pkg::ACT_POP: begin
                if (stack_top == 0) begin
                    r.status = lss_pkg::ST_EMPTY;
                end else begin
                    stack_top--;
                    r.value = stack_mem[stack_top];
                end
            end
            lss_pkg::ACT_PEEK: begin
                if (stack_top == 0) r.status = lss_pkg::ST_EMPTY;
                else r.value = stack_mem[stack_top - 1];
            end
            lss_pkg::ACT_SEARCH: begin
                if (stack_top == 0) begin
                    r.status = lss_pkg::ST_EMPTY;
                end else begin
                    for (i = stack_top - 1; i >= 0; i--) begin
                        if (stack_mem[i] == operand) r.found = 1'b1;
                    end
                end
            end
            lss_pkg::ACT_CLEAR: stack_top = 0;
            default: ;
        endcase
        r.count = lss_pkg::COUNT_W'(stack_top);
        return r;
    endfunction

    // Queues a command and keeps the generator's view of the stack in step.
    task automatic add_cmd(input logic [AW-1:0] act, input logic [VW-1:0] operand);
        t_stack_cmd c;
        c.action  = act;
        c.operand = operand;
        pending_cmds.push_back(c);
        case (act)
            lss_pkg::ACT_PUSH:  if (gen_stack.size() < DEPTH) gen_stack.push_back(operand);
            lss_pkg::ACT_POP:   if (gen_stack.size() > 0) void'(gen_stack.pop_back());
            lss_pkg::ACT_CLEAR: gen_stack.delete();
            default: ;
        endcase
    endtask

    // Push values lean on the extremes and on a few small numbers, so duplicates occur.
    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return VW'($urandom_range(15));
            3: return -VW'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    // Search operands mostly hit something held.
    function automatic logic [VW-1:0] pick_search();
        if (gen_stack.size() > 0 && $urandom_range(1))
            return gen_stack[$urandom_range(gen_stack.size() - 1)];
        return pick_value();
    endfunction

    // Fills the stack, pushes onto the full stack, then walks it with searches.
    task automatic add_fill();
        int k;
        while (gen_stack.size() < DEPTH) add_cmd(lss_pkg::ACT_PUSH, pick_value());
        for (k = 0; k <= $urandom_range(1); k++) add_cmd(lss_pkg::ACT_PUSH, pick_value());
        for (k = 0; k <= $urandom_range(2); k++) add_cmd(lss_pkg::ACT_SEARCH, pick_search());
    endtask

    // Idle percentages per third of the run: receiver first, then sender, then none.
    function automatic int idle_pct(input bit receiver);
        int third;
        third = (sent_count * 3) / total_cmds;
        case (third)
            0: return receiver ? 87 : 31;
            1: return receiver ? 31 : 87;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VW-1:0] want,
                                   input logic [VW-1:0] got);
        if (err_count < PRINT_LIMIT)
            $display("mismatch on result %0d: %s expected %0h got %0h",
                     result_count, what, want, got);
        err_count++;
    endtask

    // Driver: predicts each accepted transfer and presents the next command.
    always @(posedge i_clk) begin : driver
        t_stack_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(stack_predict(s_axis_tuser, s_axis_tdata));
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    c = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= c.action;
                    s_axis_tdata  <= c.operand;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every result transfer with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        lss_pkg::t_result got;
        lss_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = lss_pkg::t_result'(m_axis_tdata[$bits(lss_pkg::t_result)-1:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, tdata", '0, m_axis_tdata[VW-1:0]);
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("result_value", want.value, got.value);
                    if (got.found !== want.found)
                        report_mismatch("found", VW'(want.found), VW'(got.found));
                    if (got.count !== want.count)
                        report_mismatch("entry_count", VW'(want.count), VW'(got.count));
                    if (got.status !== want.status)
                        report_mismatch("status", VW'(want.status), VW'(got.status));
                    if (m_axis_tdata[lss_pkg::OUT_W-1:$bits(lss_pkg::t_result)] !== '0)
                        report_mismatch("pad bits", '0,
                            VW'(m_axis_tdata[lss_pkg::OUT_W-1:$bits(lss_pkg::t_result)]));
                end
                result_count++;
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    initial begin
        int n;
        int k;
        int len;

        // Directed: empty-stack errors, spare codes, extreme values, hit and miss.
        add_cmd(lss_pkg::ACT_COUNT, 32'h0);
        add_cmd(lss_pkg::ACT_POP, 32'h0);
        add_cmd(lss_pkg::ACT_PEEK, 32'hFFFF_FFFF);
        add_cmd(lss_pkg::ACT_SEARCH, 32'h0);
        add_cmd(lss_pkg::ACT_CLEAR, 32'h0);
        add_cmd(ACT_SPARE_6, 32'h0);
        add_cmd(ACT_SPARE_7, 32'hFFFF_FFFF);
        add_cmd(lss_pkg::ACT_PUSH, 32'h8000_0000);
        add_cmd(lss_pkg::ACT_PUSH, 32'h7FFF_FFFF);
        add_cmd(lss_pkg::ACT_PUSH, 32'h0);
        add_cmd(lss_pkg::ACT_PUSH, 32'hFFFF_FFFF);
        add_cmd(lss_pkg::ACT_PEEK, 32'h0);
        add_cmd(lss_pkg::ACT_SEARCH, 32'h8000_0000);
        add_cmd(lss_pkg::ACT_SEARCH, 32'h1234_5678);
        add_cmd(lss_pkg::ACT_COUNT, 32'hFFFF_FFFF);
        add_cmd(lss_pkg::ACT_POP, 32'h0);
        add_cmd(lss_pkg::ACT_SEARCH, 32'hFFFF_FFFF);
        add_cmd(lss_pkg::ACT_POP, 32'h0);
        add_cmd(lss_pkg::ACT_PEEK, 32'h0);
        add_cmd(ACT_SPARE_6, 32'h5555_5555);
        add_cmd(lss_pkg::ACT_CLEAR, 32'h0);
        add_cmd(lss_pkg::ACT_POP, 32'h0);
        add_cmd(lss_pkg::ACT_PUSH, 32'h1);
        add_cmd(ACT_SPARE_7, 32'h0);
        add_cmd(lss_pkg::ACT_POP, 32'h0);

        // Random: mostly push and pop runs with lookups, the first run filling the stack.
        n = pending_cmds.size();
        add_fill();
        while (pending_cmds.size() - n < RANDOM_ITEMS) begin
            len = $urandom_range(1, 8);
            case ($urandom_range(9))
                0, 1: for (k = 0; k < len; k++) add_cmd(lss_pkg::ACT_PUSH, pick_value());
                2: add_fill();
                3, 4: for (k = 0; k < len; k++) add_cmd(lss_pkg::ACT_POP, $urandom);
                5, 6: begin
                    for (k = 0; k < len; k++) begin
                        case ($urandom_range(2))
                            0: add_cmd(lss_pkg::ACT_PEEK, $urandom);
                            1: add_cmd(lss_pkg::ACT_SEARCH, pick_search());
                            default: add_cmd(lss_pkg::ACT_COUNT, $urandom);
                        endcase
                    end
                end
                7: begin
                    while (gen_stack.size() > 0) add_cmd(lss_pkg::ACT_POP, $urandom);
                    add_cmd(lss_pkg::ACT_POP, $urandom);
                    add_cmd(lss_pkg::ACT_SEARCH, pick_value());
                    add_cmd(lss_pkg::ACT_PEEK, $urandom);
                end
                8: begin
                    add_cmd(lss_pkg::ACT_CLEAR, $urandom);
                    add_cmd(lss_pkg::ACT_COUNT, $urandom);
                end
                default: begin
                    for (k = 0; k < len; k++)
                        add_cmd(AW'($urandom_range(7)), $urandom);
                end
            endcase
        end
        total_cmds = pending_cmds.size();

        // Drain, then allow a full-depth search time for stray results.
        while (!(pending_cmds.size() == 0 && !s_axis_tvalid && expected_results.size() == 0))
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        if (err_count == 0) begin
            $display("lifo_stack_with_search_unit regression: pass");
        end else begin
            $display("lifo_stack_with_search_unit regression: fail");
        end
        $finish;
    end

endmodule
